### design/rtcchk_pkg.sv
// Shared types, register masks, limits and the month-length table for the RTC time decode.
// No dependencies; used by rtcchk_decode and rtc_bcd_time_decode_check_top.
`default_nettype none

package rtcchk_pkg;

	// Defined bits of each raw time register
	localparam logic [7:0] SecMask  = 8'h7F;
	localparam logic [7:0] MinMask  = 8'h7F;
	localparam logic [7:0] HourMask = 8'h3F;
	localparam logic [7:0] DayMask  = 8'h3F;
	localparam logic [7:0] WdayMask = 8'h07;
	localparam logic [7:0] MonMask  = 8'h1F;

	// Largest decoded value each register may hold
	localparam logic [6:0] MaxSecond = 7'd59;
	localparam logic [6:0] MaxMinute = 7'd59;
	localparam logic [5:0] MaxHour   = 6'd23;
	localparam logic [5:0] MaxDay    = 6'd31;
	localparam logic [2:0] MaxWday   = 3'd6;
	localparam logic [4:0] MaxMonth  = 5'd12;
	localparam logic [7:0] MaxYear   = 8'd99;

	localparam logic [3:0] MaxDigit  = 4'd9;

	// Calendar window, as offsets from the century base
	localparam logic [11:0] YearBase  = 12'd2000;
	localparam logic [7:0]  YearLoOfs = 8'd24;   // 2024
	localparam logic [7:0]  YearHiOfs = 8'd99;   // 2099

	// Decoded register snapshot
	typedef struct packed {
		logic [6:0] sec;
		logic [6:0] min;
		logic [5:0] hour;
		logic [5:0] day;
		logic [2:0] wday;
		logic [4:0] mon;
		logic [7:0] yr;
	} dec_t;

	// Days in a month 1..12; other codes return 31 and are never used
	function automatic logic [4:0] days_per_month(input logic [4:0] mon, input logic leap);
		logic [4:0] d;
		d = 5'd31;
		case (mon)
			5'd2:    d = leap ? 5'd29 : 5'd28;
			5'd4, 5'd6, 5'd9, 5'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### design/rtcchk_decode.sv
// BCD decode of the seven RTC time registers, all but the year masked, plus a per-digit BCD check.
// Depends on rtcchk_pkg for masks and the dec_t snapshot type.
`default_nettype none

module rtcchk_decode import rtcchk_pkg::*; (
	input  wire logic [7:0] raw_seconds,
	input  wire logic [7:0] raw_minutes,
	input  wire logic [7:0] raw_hours,
	input  wire logic [7:0] raw_days,
	input  wire logic [7:0] raw_weekdays,
	input  wire logic [7:0] raw_months,
	input  wire logic [7:0] raw_years,
	output dec_t            dec,
	output logic            digits_ok
);

	logic [7:0] m_sec, m_min, m_hour, m_day, m_wday, m_mon;

	always_comb begin
		m_sec  = raw_seconds  & SecMask;
		m_min  = raw_minutes  & MinMask;
		m_hour = raw_hours    & HourMask;
		m_day  = raw_days     & DayMask;
		m_wday = raw_weekdays & WdayMask;
		m_mon  = raw_months   & MonMask;

		// tens * 10 + units; non-BCD units still decode as their binary value
		dec.sec  = 7'({m_sec[6:4], 3'b000} + {3'b000, m_sec[6:4], 1'b0}) + 7'(m_sec[3:0]);
		dec.min  = 7'({m_min[6:4], 3'b000} + {3'b000, m_min[6:4], 1'b0}) + 7'(m_min[3:0]);
		dec.hour = 6'({m_hour[5:4], 3'b000} + {3'b000, m_hour[5:4], 1'b0}) + 6'(m_hour[3:0]);
		dec.day  = 6'({m_day[5:4], 3'b000} + {3'b000, m_day[5:4], 1'b0}) + 6'(m_day[3:0]);
		dec.wday = m_wday[2:0];
		dec.mon  = (m_mon[4] ? 5'd10 : 5'd0) + 5'(m_mon[3:0]);
		dec.yr   = 8'({raw_years[7:4], 3'b000}) + 8'({raw_years[7:4], 1'b0})
		         + 8'(raw_years[3:0]);

		// Narrow tens fields cannot exceed nine; check the rest
		digits_ok = (m_sec[3:0]  <= MaxDigit) && (m_min[3:0] <= MaxDigit)
		         && (m_hour[3:0] <= MaxDigit) && (m_day[3:0] <= MaxDigit)
		         && (m_mon[3:0]  <= MaxDigit) && (raw_years[3:0] <= MaxDigit)
		         && (raw_years[7:4] <= MaxDigit);
	end

endmodule

`default_nettype wire

### design/rtc_bcd_time_decode_check_top.sv
// Top level of the RTC time register decode and check: three-stage pipeline with handshakes.
// Depends on rtcchk_pkg and rtcchk_decode.
`default_nettype none

// Takes one snapshot of the seven raw BCD time registers per word and returns one
// decoded word: second, minute, hour, day of month, weekday and month as binary
// values, the year as 2000 plus the decoded year byte, the voltage-low flag (bit 7
// of the seconds register) on supply_low, raw_valid (every digit is BCD and every
// value is within its register's maximum) and date_valid (a real calendar moment in
// 2024..2099 with the Gregorian leap rule, hour <= 23, minute and second <= 59,
// weekday <= 6). Bits outside each register's defined field are ignored. date_valid
// looks only at the decoded values, so it can be set while raw_valid is clear. The
// block is a three-stage pipeline: stage 1 masks and decodes the digits, stage 2
// runs the limit compares and looks up the month length, stage 3 finishes the day
// check and is the output register. A word can enter every cycle while in_ready
// is high; out_valid rises once the word has been registered in stage 1, then in
// stage 2 and then in stage 3. Each stage holds while the one after it is full and
// stalled, so a stall on the output loses and repeats nothing, and in_ready stays
// high as long as any stage has room.

module rtc_bcd_time_decode_check_top import rtcchk_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  raw_seconds,
	input  wire logic [7:0]  raw_minutes,
	input  wire logic [7:0]  raw_hours,
	input  wire logic [7:0]  raw_days,
	input  wire logic [7:0]  raw_weekdays,
	input  wire logic [7:0]  raw_months,
	input  wire logic [7:0]  raw_years,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       second,
	output logic [6:0]       minute,
	output logic [5:0]       hour,
	output logic [5:0]       day_of_month,
	output logic [2:0]       weekday,
	output logic [4:0]       month,
	output logic [11:0]      year,
	output logic             supply_low,
	output logic             raw_valid,
	output logic             date_valid
);

	// Stage valid bits and per-stage advance enables
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	// A stage takes a new word when it is empty or its word moves on this cycle
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// ---------------- Stage 1: mask and decode ----------------
	dec_t dec_c;
	logic digits_ok_c;

	rtcchk_decode u_decode (
		.raw_seconds  (raw_seconds),
		.raw_minutes  (raw_minutes),
		.raw_hours    (raw_hours),
		.raw_days     (raw_days),
		.raw_weekdays (raw_weekdays),
		.raw_months   (raw_months),
		.raw_years    (raw_years),
		.dec          (dec_c),
		.digits_ok    (digits_ok_c)
	);

	dec_t dec_s1;
	logic digits_ok_s1, vlow_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			dec_s1       <= dec_c;
			digits_ok_s1 <= digits_ok_c;
			vlow_s1      <= raw_seconds[7];
		end
	end

	// ---------------- Stage 2: limits and month length ----------------
	logic       raw_ok_c, date_pre_c, leap_c;
	logic [4:0] max_day_c;

	always_comb begin
		raw_ok_c = digits_ok_s1
		        && (dec_s1.sec  <= MaxSecond) && (dec_s1.min  <= MaxMinute)
		        && (dec_s1.hour <= MaxHour)   && (dec_s1.day  <= MaxDay)
		        && (dec_s1.wday <= MaxWday)   && (dec_s1.mon  <= MaxMonth)
		        && (dec_s1.yr   <= MaxYear);

		date_pre_c = (dec_s1.yr >= YearLoOfs) && (dec_s1.yr <= YearHiOfs)
		          && (dec_s1.mon >= 5'd1) && (dec_s1.mon <= MaxMonth)
		          && (dec_s1.day >= 6'd1)
		          && (dec_s1.hour <= MaxHour) && (dec_s1.min <= MaxMinute)
		          && (dec_s1.sec <= MaxSecond) && (dec_s1.wday <= MaxWday);

		// Inside 2024..2099 no century year occurs, so divisible by four is the full rule;
		// outside that window date_pre_c already fails
		leap_c    = (dec_s1.yr[1:0] == 2'b00);
		max_day_c = days_per_month(dec_s1.mon, leap_c);
	end

	dec_t       dec_s2;
	logic       raw_ok_s2, date_pre_s2, vlow_s2;
	logic [4:0] max_day_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			dec_s2      <= dec_s1;
			raw_ok_s2   <= raw_ok_c;
			date_pre_s2 <= date_pre_c;
			vlow_s2     <= vlow_s1;
			max_day_s2  <= max_day_c;
		end
	end

	// ---------------- Stage 3: day check, year, output register ----------------
	dec_t        dec_s3;
	logic [11:0] year_s3;
	logic        raw_ok_s3, date_ok_s3, vlow_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			dec_s3     <= dec_s2;
			year_s3    <= YearBase + {4'b0000, dec_s2.yr};
			raw_ok_s3  <= raw_ok_s2;
			date_ok_s3 <= date_pre_s2 && (dec_s2.day <= {1'b0, max_day_s2});
			vlow_s3    <= vlow_s2;
		end
	end

	assign out_valid    = v_s3;
	assign second       = dec_s3.sec;
	assign minute       = dec_s3.min;
	assign hour         = dec_s3.hour;
	assign day_of_month = dec_s3.day;
	assign weekday      = dec_s3.wday;
	assign month        = dec_s3.mon;
	assign year         = year_s3;
	assign supply_low   = vlow_s3;
	assign raw_valid    = raw_ok_s3;
	assign date_valid   = date_ok_s3;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for rtc_bcd_time_decode_check_top: random and directed register
// snapshots in, decoded time words checked against an in-bench decoder.
// Depends on rtcchk_pkg and the design files under design/.

module testbench import rtcchk_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_WORDS = 1000;
	localparam int unsigned MAX_WAIT     = 14;
	localparam int unsigned DRAIN_CYCLES = 20;
	// Long receiver hold-offs, in cycles after reset, so the pipeline fills and
	// backs up onto in_ready
	localparam int unsigned HOLD1_START = 400;
	localparam int unsigned HOLD1_END   = 600;
	localparam int unsigned HOLD2_START = 5000;
	localparam int unsigned HOLD2_END   = 5150;
	localparam longint unsigned TIMEOUT_NS = 64'd2_000_000;

	// One snapshot of the seven raw time registers
	typedef struct packed {
		logic [7:0] sec;
		logic [7:0] min;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] wday;
		logic [7:0] mon;
		logic [7:0] yr;
	} raw_snapshot_t;

	// One decoded word as the block should return it
	typedef struct packed {
		logic [6:0]  second;
		logic [6:0]  minute;
		logic [5:0]  hour;
		logic [5:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  month;
		logic [11:0] year;
		logic        supply_low;
		logic        raw_valid;
		logic        date_valid;
	} time_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  raw_seconds = 8'h00;
	logic [7:0]  raw_minutes = 8'h00;
	logic [7:0]  raw_hours = 8'h00;
	logic [7:0]  raw_days = 8'h00;
	logic [7:0]  raw_weekdays = 8'h00;
	logic [7:0]  raw_months = 8'h00;
	logic [7:0]  raw_years = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  second;
	logic [6:0]  minute;
	logic [5:0]  hour;
	logic [5:0]  day_of_month;
	logic [2:0]  weekday;
	logic [4:0]  month;
	logic [11:0] year;
	logic        supply_low;
	logic        raw_valid;
	logic        date_valid;

	raw_snapshot_t snapshot_q[$];     // snapshots still to be offered
	time_word_t    decoded_q[$];      // decoded words the block still owes us
	raw_snapshot_t offer_next;
	int unsigned   send_gap;
	int unsigned   send_quiet;
	int unsigned   recv_wait;
	int unsigned   recv_quiet;
	int unsigned   run_cycles;
	int unsigned   mismatches;
	int unsigned   words_checked;
	logic          hold_off = 1'b0;

	rtc_bcd_time_decode_check_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_seconds(raw_seconds),
		.raw_minutes(raw_minutes),
		.raw_hours(raw_hours),
		.raw_days(raw_days),
		.raw_weekdays(raw_weekdays),
		.raw_months(raw_months),
		.raw_years(raw_years),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.second(second),
		.minute(minute),
		.hour(hour),
		.day_of_month(day_of_month),
		.weekday(weekday),
		.month(month),
		.year(year),
		.supply_low(supply_low),
		.raw_valid(raw_valid),
		.date_valid(date_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Days in a month of a given full year, with the Gregorian leap rule
	function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
		logic leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Expected decoded word for one register snapshot: mask, BCD-decode, range
	// checks on the raw digits, then the calendar check on the decoded values
	function automatic time_word_t decode_snapshot(input raw_snapshot_t r);
		logic [7:0]  regs [0:6];
		logic [7:0]  masks [0:6];
		int unsigned limits [0:6];
		logic [7:0]  masked;
		int unsigned dec [0:6];
		int unsigned full_year;
		logic        raw_ok;
		logic        date_ok;
		time_word_t  w;
		regs   = '{r.sec, r.min, r.hour, r.day, r.wday, r.mon, r.yr};
		masks  = '{SecMask, MinMask, HourMask, DayMask, WdayMask, MonMask, 8'hFF};
		limits = '{MaxSecond, MaxMinute, MaxHour, MaxDay, MaxWday, MaxMonth, MaxYear};
		raw_ok = 1'b1;
		for (int i = 0; i < 7; i++) begin
			masked = regs[i] & masks[i];
			// non-BCD nibbles still decode, units may run up to 15
			dec[i] = int'(masked[7:4]) * 10 + int'(masked[3:0]);
			if (masked[7:4] > MaxDigit || masked[3:0] > MaxDigit || dec[i] > limits[i])
				raw_ok = 1'b0;
		end
		full_year = YearBase + dec[6];
		// calendar check looks only at decoded values, not at raw_ok
		date_ok = full_year >= YearBase + YearLoOfs && full_year <= YearBase + YearHiOfs &&
			dec[5] >= 1 && dec[5] <= MaxMonth && dec[3] >= 1 &&
			dec[2] <= MaxHour && dec[1] <= MaxMinute && dec[0] <= MaxSecond &&
			dec[4] <= MaxWday;
		if (date_ok && dec[3] > month_len(full_year, dec[5]))
			date_ok = 1'b0;
		w.second       = dec[0][6:0];
		w.minute       = dec[1][6:0];
		w.hour         = dec[2][5:0];
		w.day_of_month = dec[3][5:0];
		w.weekday      = dec[4][2:0];
		w.month        = dec[5][4:0];
		w.year         = full_year[11:0];
		w.supply_low   = r.sec[7];
		w.raw_valid    = raw_ok;
		w.date_valid   = date_ok;
		return w;
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Now and then set the bits outside a register's field; they must not matter
	function automatic logic [7:0] add_stray_bits(input logic [7:0] b, input logic [7:0] mask);
		if ($urandom_range(0, 3) == 0)
			return b | (8'($urandom) & ~mask);
		return b;
	endfunction

	// Idle cycles before the next word on one side: runs with no idling now and
	// then, otherwise 0..MAX_WAIT with a lean toward zero
	function automatic int unsigned draw_wait(inout int unsigned quiet_left);
		if (quiet_left != 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic queue_snapshot(input logic [7:0] s, input logic [7:0] mi, input logic [7:0] h,
			input logic [7:0] d, input logic [7:0] wd, input logic [7:0] mo, input logic [7:0] y);
		snapshot_q.push_back('{sec: s, min: mi, hour: h, day: d, wday: wd, mon: mo, yr: y});
	endtask

	task automatic flag_mismatch(input string field, input int got, input int want);
		mismatches++;
		$display("%0t: word %0d %s: got %0d expected %0d",
			$realtime, words_checked, field, got, want);
	endtask

	// Compare the word on the output against the oldest pending decode
	task automatic check_word();
		time_word_t want;
		if (decoded_q.size() == 0) begin
			flag_mismatch("arrived with nothing pending", 0, 0);
			return;
		end
		want = decoded_q.pop_front();
		if (second !== want.second)            flag_mismatch("second", second, want.second);
		if (minute !== want.minute)            flag_mismatch("minute", minute, want.minute);
		if (hour !== want.hour)                flag_mismatch("hour", hour, want.hour);
		if (day_of_month !== want.day_of_month)
			flag_mismatch("day_of_month", day_of_month, want.day_of_month);
		if (weekday !== want.weekday)          flag_mismatch("weekday", weekday, want.weekday);
		if (month !== want.month)              flag_mismatch("month", month, want.month);
		if (year !== want.year)                flag_mismatch("year", year, want.year);
		if (supply_low !== want.supply_low)
			flag_mismatch("supply_low", supply_low, want.supply_low);
		if (raw_valid !== want.raw_valid)      flag_mismatch("raw_valid", raw_valid, want.raw_valid);
		if (date_valid !== want.date_valid)
			flag_mismatch("date_valid", date_valid, want.date_valid);
		words_checked++;
	endtask

	// Driver: hold the word until accepted, then wait out the drawn gap and
	// offer the next one from the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			raw_seconds  <= 8'h00;
			raw_minutes  <= 8'h00;
			raw_hours    <= 8'h00;
			raw_days     <= 8'h00;
			raw_weekdays <= 8'h00;
			raw_months   <= 8'h00;
			raw_years    <= 8'h00;
			send_gap     = 0;
			send_quiet   = 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (snapshot_q.size() != 0) begin
				offer_next = snapshot_q.pop_front();
				raw_seconds  <= offer_next.sec;
				raw_minutes  <= offer_next.min;
				raw_hours    <= offer_next.hour;
				raw_days     <= offer_next.day;
				raw_weekdays <= offer_next.wday;
				raw_months   <= offer_next.mon;
				raw_years    <= offer_next.yr;
				in_valid     <= 1'b1;
				send_gap     = draw_wait(send_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: record the decode of every accepted input word, check every
	// accepted output word, then draw the receiver's stall for the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_wait  = 0;
			recv_quiet = 0;
		end else begin
			if (in_valid && in_ready)
				decoded_q.push_back(decode_snapshot('{sec: raw_seconds, min: raw_minutes,
					hour: raw_hours, day: raw_days, wday: raw_weekdays,
					mon: raw_months, yr: raw_years}));
			if (out_valid && out_ready) begin
				check_word();
				recv_wait = draw_wait(recv_quiet);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0) && !hold_off;
		end
	end

	// Long receiver hold-off, timed by its own cycle count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off   <= 1'b0;
			run_cycles = 0;
		end else begin
			run_cycles++;
			hold_off <= (run_cycles >= HOLD1_START && run_cycles < HOLD1_END) ||
				(run_cycles >= HOLD2_START && run_cycles < HOLD2_END);
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int unsigned pick;
		int unsigned y;
		int unsigned mo;
		int unsigned d;
		mismatches    = 0;
		words_checked = 0;

		// Directed: extremes, window edges, leap years, non-BCD digits, stray bits
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h99);  // last valid moment
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h24);  // first valid moment
		queue_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h23);  // year before window
		queue_snapshot(8'h10, 8'h20, 8'h12, 8'h29, 8'h04, 8'h02, 8'h24);  // leap day
		queue_snapshot(8'h10, 8'h20, 8'h12, 8'h29, 8'h04, 8'h02, 8'h25);  // no leap day
		queue_snapshot(8'h10, 8'h20, 8'h12, 8'h28, 8'h04, 8'h02, 8'h25);
		queue_snapshot(8'h10, 8'h20, 8'h12, 8'h29, 8'h04, 8'h02, 8'h96);
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h31, 8'h01, 8'h04, 8'h30);  // April 31
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h30, 8'h01, 8'h09, 8'h30);
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h31, 8'h01, 8'h11, 8'h30);
		// hours 0x1A decodes to 20: raw check fails, calendar check passes
		queue_snapshot(8'h05, 8'h05, 8'h1A, 8'h15, 8'h02, 8'h06, 8'h50);
		queue_snapshot(8'hD9, 8'h30, 8'h12, 8'h15, 8'h03, 8'h07, 8'h40);  // voltage low
		queue_snapshot(8'h45, 8'hB0, 8'hD2, 8'hD5, 8'hFB, 8'hE7, 8'h40);  // stray bits set
		queue_snapshot(8'h60, 8'h60, 8'h24, 8'h32, 8'h07, 8'h13, 8'h40);  // BCD above limits
		queue_snapshot(8'h7F, 8'h0F, 8'h0F, 8'h0F, 8'h05, 8'h0F, 8'h2F);  // units nibble 15
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h40);  // month zero
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h40);  // day zero
		queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h9A);  // year 2100
		queue_snapshot(8'h3A, 8'h5F, 8'h3F, 8'h3F, 8'h07, 8'h1F, 8'hA0);  // top of the hour, day, weekday and month fields

		// Random: a mix of real calendar moments (half the words), edges around month
		// ends and field limits, and raw noise
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				y  = $urandom_range(24, 99);
				mo = $urandom_range(1, 12);
				d  = $urandom_range(1, month_len(2000 + y, mo));
				queue_snapshot(to_bcd($urandom_range(0, 59)) | {1'($urandom), 7'd0},
					add_stray_bits(to_bcd($urandom_range(0, 59)), MinMask),
					add_stray_bits(to_bcd($urandom_range(0, 23)), HourMask),
					add_stray_bits(to_bcd(d), DayMask),
					add_stray_bits(to_bcd($urandom_range(0, 6)), WdayMask),
					add_stray_bits(to_bcd(mo), MonMask),
					to_bcd(y));
			end else if (pick < 7) begin
				y  = $urandom_range(0, 1) ? 4 * $urandom_range(6, 24) : $urandom_range(20, 99);
				mo = $urandom_range(0, 3) == 0 ? 2 : $urandom_range(1, 12);
				d  = month_len(2000 + y, mo) + $urandom_range(0, 2) - 1;
				queue_snapshot(to_bcd($urandom_range(58, 60)) | {1'($urandom), 7'd0},
					to_bcd($urandom_range(58, 60)),
					to_bcd($urandom_range(22, 24)),
					to_bcd(d),
					to_bcd($urandom_range(5, 7)),
					to_bcd(mo),
					to_bcd(y));
			end else begin
				queue_snapshot(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			end
		end

		// Reset once, then release between edges
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last word to go in, then for every decode to come back
		while (snapshot_q.size() != 0 || in_valid)
			@(negedge clk);
		while (decoded_q.size() != 0)
			@(negedge clk);
		// Allow any stray extra word to surface
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
